[src/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion sampled on clk, masked while reset is active.
`define SSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent assertion sampled on clk that also holds during reset.
`define SSS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[src/sss_pkg.sv]
// Shared types and constants for the state-space simulator.
package sss_pkg;

  // Request kinds carried on in_tuser.
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_STATE  = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // Coefficient matrix selectors.
  localparam logic [1:0] MAT_A = 2'd0;
  localparam logic [1:0] MAT_B = 2'd1;
  localparam logic [1:0] MAT_C = 2'd2;
  localparam logic [1:0] MAT_D = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STATES  = 2'd0;
  localparam logic [1:0] CFG_INPUTS  = 2'd1;
  localparam logic [1:0] CFG_OUTPUTS = 2'd2;

  localparam int ACC_W  = 40;
  localparam int PROD_W = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_ROW_END,
    ST_OUT,
    ST_COMMIT
  } sss_state_t;

  // Saturate a row sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [31:0] r;
    if (v > $signed(ACC_W'(32'sh7fffffff))) begin
      r = 32'h7fffffff;
    end else if (v < -$signed(ACC_W'(64'h80000000))) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[src/sss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/state_space_system_simulator.sv]
// Top level: fixed-point discrete state-space simulator with one shared MAC.
// Load and state-set requests and non-closing sample elements leave the block idle and ready.
// A closing sample passes a start state, then computes p output rows and n state rows
// on the shared MAC, stepping read, multiply and accumulate for each term; each result waits
// for the sink, a commit state follows when n is nonzero, and with p zero it stops at start.
// rst_n is synchronous and active low; coefficients and state read as zero after reset.
module state_space_system_simulator #(
  parameter int MAX_STATES  = 8,
  parameter int MAX_INPUTS  = 8,
  parameter int MAX_OUTPUTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // matrix_select[1:0], row_index[4:2], col_index[7:5], value[39:8]
  input  logic [39:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // output_index[2:0], output_value[34:3], zero pad[39:35]
  output logic [39:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int LIM_S = (MAX_STATES < 8) ? MAX_STATES : 8;
  localparam int LIM_M = (MAX_INPUTS < 8) ? MAX_INPUTS : 8;
  localparam int LIM_P = (MAX_OUTPUTS < 15) ? MAX_OUTPUTS : 15;

  // Request fields.
  logic [1:0]  f_sel;
  logic [2:0]  f_row, f_col;
  logic [31:0] f_val;
  logic        accept;

  assign f_sel  = in_tdata[1:0];
  assign f_row  = in_tdata[4:2];
  assign f_col  = in_tdata[7:5];
  assign f_val  = in_tdata[39:8];
  assign accept = in_tvalid && in_tready;

  // Configuration registers.
  logic [3:0] n_cnt_r, m_cnt_r, p_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_cnt_r <= '0;
      m_cnt_r <= '0;
      p_cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sss_pkg::CFG_STATES:  n_cnt_r <= cfg_data;
        sss_pkg::CFG_INPUTS:  m_cnt_r <= cfg_data;
        sss_pkg::CFG_OUTPUTS: p_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective counts; rows and columns past eight are never stored and read as zero.
  logic [3:0] n_c, m_c, p_c;
  logic [4:0] total_c;

  always_comb begin
    n_c = (n_cnt_r > 4'(LIM_S)) ? 4'(LIM_S) : n_cnt_r;
    m_c = (m_cnt_r > 4'(LIM_M)) ? 4'(LIM_M) : m_cnt_r;
    p_c = (p_cnt_r > 4'(LIM_P)) ? 4'(LIM_P) : p_cnt_r;
    total_c = 5'(n_c) + 5'(m_c);
  end

  // Sequencer state and datapath registers.
  sss_pkg::sss_state_t state_r, state_nxt;
  logic                phase_r;
  logic [3:0]          row_r;
  logic [4:0]          term_r;
  logic                zero_r, rvld_r;
  logic signed [31:0]  opnd_r;
  logic signed [sss_pkg::PROD_W-1:0] prod_r;
  logic signed [sss_pkg::ACC_W-1:0]  acc_r;
  logic [31:0]         xv_r  [8];
  logic [31:0]         nsb_r [8];
  logic [15:0]         ub_r  [8];
  logic [3:0][63:0]    vld_r;
  logic                out_tvalid_r, out_last_r;
  logic [2:0]          out_idx_r;
  logic [31:0]         out_val_r;

  // Coefficient RAMs, one per matrix.
  logic [15:0] rd_data [4];
  logic [5:0]  raddr;
  logic [3:0]  wr_en;
  logic [1:0]  rsel_c, msel_r;
  logic        hi_c;
  logic [4:0]  col_c;

  always_comb begin
    wr_en = '0;
    if (accept && in_tuser == sss_pkg::MODE_LOAD) begin
      case (f_sel)
        sss_pkg::MAT_A: wr_en[0] = (6'(f_row) < 6'(MAX_STATES)) &&
                                   (6'(f_col) < 6'(MAX_STATES));
        sss_pkg::MAT_B: wr_en[1] = (6'(f_row) < 6'(MAX_STATES)) &&
                                   (6'(f_col) < 6'(MAX_INPUTS));
        sss_pkg::MAT_C: wr_en[2] = (6'(f_row) < 6'(MAX_OUTPUTS)) &&
                                   (6'(f_col) < 6'(MAX_STATES));
        sss_pkg::MAT_D: wr_en[3] = (6'(f_row) < 6'(MAX_OUTPUTS)) &&
                                   (6'(f_col) < 6'(MAX_INPUTS));
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_mat
    sss_ram #(.WIDTH(16), .DEPTH(64)) u_ram (
      .clk   (clk),
      .we    (wr_en[g]),
      .waddr ({f_row, f_col}),
      .wdata (f_val[15:0]),
      .raddr (raddr),
      .rdata (rd_data[g])
    );
  end

  // Read address and operand selection for the current term.
  always_comb begin
    hi_c   = term_r >= 5'(n_c);
    col_c  = hi_c ? (term_r - 5'(n_c)) : term_r;
    raddr  = {row_r[2:0], col_c[2:0]};
    rsel_c = phase_r ? (hi_c ? sss_pkg::MAT_B : sss_pkg::MAT_A)
                     : (hi_c ? sss_pkg::MAT_D : sss_pkg::MAT_C);
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sss_pkg::ST_IDLE:
        if (accept && in_tuser == sss_pkg::MODE_SAMPLE && in_tlast) begin
          state_nxt = sss_pkg::ST_START;
        end
      sss_pkg::ST_START:  state_nxt = (p_c == 4'd0) ? sss_pkg::ST_IDLE : sss_pkg::ST_RD;
      sss_pkg::ST_RD:     state_nxt = (term_r == total_c) ? sss_pkg::ST_ROW_END
                                                          : sss_pkg::ST_MUL;
      sss_pkg::ST_MUL:    state_nxt = sss_pkg::ST_ACC;
      sss_pkg::ST_ACC:    state_nxt = sss_pkg::ST_RD;
      sss_pkg::ST_ROW_END:
        if (!phase_r) begin
          state_nxt = sss_pkg::ST_OUT;
        end else if (row_r == n_c - 4'd1) begin
          state_nxt = sss_pkg::ST_COMMIT;
        end else begin
          state_nxt = sss_pkg::ST_RD;
        end
      sss_pkg::ST_OUT:
        if (out_tvalid_r && out_tready) begin
          if (row_r == p_c - 4'd1 && n_c == 4'd0) begin
            state_nxt = sss_pkg::ST_IDLE;
          end else begin
            state_nxt = sss_pkg::ST_RD;
          end
        end
      sss_pkg::ST_COMMIT: state_nxt = sss_pkg::ST_IDLE;
      default:            state_nxt = sss_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_tready  = (state_r == sss_pkg::ST_IDLE);
    out_tvalid = out_tvalid_r;
    out_tlast  = out_last_r;
    out_tdata  = {5'd0, out_val_r, out_idx_r};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sss_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
      vld_r        <= '0;
    end else begin
      state_r <= state_nxt;
      for (int k = 0; k < 4; k++) begin
        if (wr_en[k]) begin
          vld_r[k][{f_row, f_col}] <= 1'b1;
        end
      end
      if (state_r == sss_pkg::ST_ROW_END && !phase_r) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // State vector: cleared at reset, set by requests, updated at commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) begin
        xv_r[k] <= '0;
      end
    end else if (accept && in_tuser == sss_pkg::MODE_STATE &&
                 6'(f_row) < 6'(MAX_STATES)) begin
      xv_r[f_row] <= f_val;
    end else if (state_r == sss_pkg::ST_COMMIT) begin
      for (int k = 0; k < 8; k++) begin
        if (4'(k) < n_c) begin
          xv_r[k] <= nsb_r[k];
        end
      end
    end
  end

  // Sample input capture, shared MAC datapath and row bookkeeping.
  always_ff @(posedge clk) begin
    if (accept && in_tuser == sss_pkg::MODE_SAMPLE && 6'(f_col) < 6'(MAX_INPUTS)) begin
      ub_r[f_col] <= f_val[15:0];
    end
    case (state_r)
      sss_pkg::ST_START: begin
        phase_r <= 1'b0;
        row_r   <= '0;
        term_r  <= '0;
        acc_r   <= '0;
      end
      sss_pkg::ST_RD: begin
        msel_r <= rsel_c;
        zero_r <= row_r[3];
        rvld_r <= vld_r[rsel_c][raddr];
        opnd_r <= hi_c ? 32'(signed'(ub_r[col_c[2:0]])) : signed'(xv_r[col_c[2:0]]);
      end
      sss_pkg::ST_MUL: begin
        prod_r <= ((zero_r || !rvld_r) ? 16'sd0 : signed'(rd_data[msel_r])) * opnd_r;
      end
      sss_pkg::ST_ACC: begin
        acc_r  <= acc_r + sss_pkg::ACC_W'(prod_r >>> 13);
        term_r <= term_r + 5'd1;
      end
      sss_pkg::ST_ROW_END: begin
        if (!phase_r) begin
          out_idx_r  <= row_r[2:0];
          out_val_r  <= sss_pkg::sat32(acc_r);
          out_last_r <= (row_r == p_c - 4'd1);
        end else begin
          nsb_r[row_r[2:0]] <= sss_pkg::sat32(acc_r);
          row_r  <= row_r + 4'd1;
          term_r <= '0;
          acc_r  <= '0;
        end
      end
      sss_pkg::ST_OUT: begin
        if (out_tvalid_r && out_tready) begin
          term_r <= '0;
          acc_r  <= '0;
          if (row_r == p_c - 4'd1) begin
            phase_r <= 1'b1;
            row_r   <= '0;
          end else begin
            row_r <= row_r + 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[src/sss_chk.sv]
// Port-level checker for the state-space simulator, bound to the top level.
`include "assert_macros.svh"
module sss_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  logic out_stall;
  logic close_req;

  assign out_stall = out_tvalid && !out_tready;
  assign close_req = in_tvalid && in_tready && in_tuser == sss_pkg::MODE_SAMPLE && in_tlast;

  // A result waiting for the sink keeps its data.
  `SSS_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  // The block never takes a request while a result is pending.
  `SSS_ASSERT(a_no_overlap, !(in_tready && out_tvalid), "request taken while result pending")
  // A closing sample element starts a computation and drops ready.
  `SSS_ASSERT(a_close_busy, close_req |=> !in_tready, "ready after closing sample")
  // No result comes out right after reset.
  `SSS_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_tvalid, "result after reset")

endmodule

bind state_space_system_simulator sss_chk u_sss_chk (.*);

[dv/tb_state_space_system_simulator.sv]
// Testbench for the state-space simulator: predicts each output row and checks the stream.
`timescale 1ns / 1ps

// Holds a copy of the system state and the queue of predicted output rows.
class sss_scoreboard;
  int unsigned n_states, n_inputs, n_outputs;
  logic signed [15:0] coef_a [8][8];
  logic signed [15:0] coef_b [8][8];
  logic signed [15:0] coef_c [8][8];
  logic signed [15:0] coef_d [8][8];
  logic signed [31:0] xvec [8];
  logic signed [15:0] uvec [8];
  logic [35:0] pending_rows [$];
  int errors;

  function new();
    for (int i = 0; i < 8; i++) begin
      xvec[i] = 0;
      uvec[i] = 0;
      for (int j = 0; j < 8; j++) begin
        coef_a[i][j] = 0;
        coef_b[i][j] = 0;
        coef_c[i][j] = 0;
        coef_d[i][j] = 0;
      end
    end
    n_states = 0;
    n_inputs = 0;
    n_outputs = 0;
    errors = 0;
  endfunction

  function void set_count(logic [1:0] idx, logic [3:0] val);
    int unsigned v;
    v = (val > 8) ? 8 : val;
    if (idx == sss_pkg::CFG_STATES) n_states = v;
    else if (idx == sss_pkg::CFG_INPUTS) n_inputs = v;
    else if (idx == sss_pkg::CFG_OUTPUTS) n_outputs = v;
  endfunction

  // Product of a Q2.13 coefficient with a value, shifted right arithmetically.
  function longint scaled(logic signed [15:0] c, longint v);
    longint prod;
    prod = longint'(c) * v;
    return prod >>> 13;
  endfunction

  function logic signed [31:0] clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Notes an accepted request and queues the output rows it produces.
  function void note_request(logic [1:0] mode, logic [39:0] data, logic last);
    logic [1:0] sel;
    logic [2:0] row, col;
    logic [31:0] val;
    logic signed [31:0] nxt [8];
    longint acc;
    sel = data[1:0];
    row = data[4:2];
    col = data[7:5];
    val = data[39:8];
    if (mode == sss_pkg::MODE_LOAD) begin
      case (sel)
        sss_pkg::MAT_A: coef_a[row][col] = val[15:0];
        sss_pkg::MAT_B: coef_b[row][col] = val[15:0];
        sss_pkg::MAT_C: coef_c[row][col] = val[15:0];
        default: coef_d[row][col] = val[15:0];
      endcase
      return;
    end
    if (mode == sss_pkg::MODE_STATE) begin
      xvec[row] = val;
      return;
    end
    if (mode != sss_pkg::MODE_SAMPLE) return;
    uvec[col] = val[15:0];
    if (!last || n_outputs == 0) return;
    for (int i = 0; i < n_outputs; i++) begin
      acc = 0;
      for (int j = 0; j < n_states; j++) acc += scaled(coef_c[i][j], xvec[j]);
      for (int j = 0; j < n_inputs; j++) acc += scaled(coef_d[i][j], uvec[j]);
      pending_rows.push_back({i == n_outputs - 1, clip(acc), 3'(i)});
    end
    for (int i = 0; i < n_states; i++) begin
      acc = 0;
      for (int j = 0; j < n_states; j++) acc += scaled(coef_a[i][j], xvec[j]);
      for (int j = 0; j < n_inputs; j++) acc += scaled(coef_b[i][j], uvec[j]);
      nxt[i] = clip(acc);
    end
    for (int i = 0; i < n_states; i++) xvec[i] = nxt[i];
  endfunction

  // Compares one accepted output row with the oldest prediction.
  function void check_row(logic [39:0] data, logic last);
    logic [35:0] exp_row;
    if (pending_rows.size() == 0) begin
      $error("unexpected output row: index %0d value %0d", data[2:0], $signed(data[34:3]));
      errors++;
      return;
    end
    exp_row = pending_rows.pop_front();
    if (data[2:0] !== exp_row[2:0]) begin
      $error("output_index: expected %0d, actual %0d", exp_row[2:0], data[2:0]);
      errors++;
    end
    if (data[34:3] !== exp_row[34:3]) begin
      $error("output_value: expected %0d, actual %0d",
             $signed(exp_row[34:3]), $signed(data[34:3]));
      errors++;
    end
    if (last !== exp_row[35]) begin
      $error("last_output: expected %0b, actual %0b", exp_row[35], last);
      errors++;
    end
    if (data[39:35] !== 5'd0) begin
      $error("out_tdata pad: expected 0, actual %0h", data[39:35]);
      errors++;
    end
  endfunction
endclass

module tb_state_space_system_simulator;

  localparam longint CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;

  sss_scoreboard board;
  bit calm;            // no random idling in the last part of the run
  bit hold_output;     // long receiver hold-off requested
  bit hold_done;       // the long hold-off has been requested once
  int n_sent;          // accepted requests so far
  longint cycles;

  state_space_system_simulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sends one request and waits for its acceptance, with random gaps before it.
  // The valid stays high afterwards so requests can follow back to back.
  task automatic send_request(logic [1:0] mode, logic [1:0] sel, logic [2:0] row,
                              logic [2:0] col, logic [31:0] val, logic last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {val, col, row, sel};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    board.note_request(mode, {val, col, row, sel}, last);
    n_sent++;
  endtask

  // Writes the three count registers on consecutive cycles.
  task automatic write_config(logic [3:0] n_val, logic [3:0] m_val, logic [3:0] p_val);
    cfg_we    <= 1'b1;
    cfg_index <= sss_pkg::CFG_STATES;
    cfg_data  <= n_val;
    @(posedge clk);
    cfg_index <= sss_pkg::CFG_INPUTS;
    cfg_data  <= m_val;
    @(posedge clk);
    cfg_index <= sss_pkg::CFG_OUTPUTS;
    cfg_data  <= p_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_count(sss_pkg::CFG_STATES, n_val);
    board.set_count(sss_pkg::CFG_INPUTS, m_val);
    board.set_count(sss_pkg::CFG_OUTPUTS, p_val);
  endtask

  // Waits until every predicted row has arrived, then lets the block settle.
  task automatic drain_rows();
    in_tvalid <= 1'b0;
    while (board.pending_rows.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'h00007fff;
      1: return 32'hffff8000;
      2: return {16'($urandom()), 16'($urandom_range(0, 4095))};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_state();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 65535) - 32768;
      default: return $urandom();
    endcase
  endfunction

  // One time sample: every used input element, the last one closing the sample.
  task automatic send_sample(int unsigned m_used);
    int unsigned k;
    k = (m_used == 0) ? 1 : m_used;
    for (int unsigned j = 0; j < k; j++)
      send_request(sss_pkg::MODE_SAMPLE, 2'($urandom()), 3'(j), 3'(j), rand_coef(),
                   j == k - 1);
  endtask

  // Loads a random system of the current size, with matching initial state.
  task automatic load_system(int unsigned n, int unsigned m, int unsigned p);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++)
        if ($urandom_range(0, 2) != 0)
          send_request(sss_pkg::MODE_LOAD, sss_pkg::MAT_A, 3'(i), 3'(j), rand_coef(), 1'b0);
      for (int j = 0; j < m; j++)
        if ($urandom_range(0, 2) != 0)
          send_request(sss_pkg::MODE_LOAD, sss_pkg::MAT_B, 3'(i), 3'(j), rand_coef(), 1'b0);
      send_request(sss_pkg::MODE_STATE, 2'($urandom()), 3'(i), 3'($urandom()), rand_state(),
                   1'($urandom()));
    end
    for (int i = 0; i < p; i++) begin
      for (int j = 0; j < n; j++)
        if ($urandom_range(0, 2) != 0)
          send_request(sss_pkg::MODE_LOAD, sss_pkg::MAT_C, 3'(i), 3'(j), rand_coef(), 1'b0);
      for (int j = 0; j < m; j++)
        if ($urandom_range(0, 2) != 0)
          send_request(sss_pkg::MODE_LOAD, sss_pkg::MAT_D, 3'(i), 3'(j), rand_coef(), 1'b1);
    end
  endtask

  // Receiver: random stalls, plus the long hold-off when requested.
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_output) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_output = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 13);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
        if (out_tvalid && out_tready) board.check_row(out_tdata, out_tlast);
      end
    end
  end

  // Cycle limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n, m, p;
    board = new();
    calm = 0;
    hold_output = 0;
    hold_done = 0;
    n_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero outputs, then the largest system with extreme values.
    send_request(sss_pkg::MODE_SAMPLE, sss_pkg::MAT_A, 3'd0, 3'd0, 32'h1234, 1'b1);
    drain_rows();
    write_config(4'd15, 4'd15, 4'd15);
    for (int j = 0; j < 8; j++)
      send_request(sss_pkg::MODE_SAMPLE, sss_pkg::MAT_D, 3'd0, 3'(j), 32'hffff8000, j == 7);
    send_request(sss_pkg::MODE_LOAD, sss_pkg::MAT_A, 3'd7, 3'd7, 32'h7fffffff, 1'b0);
    send_request(sss_pkg::MODE_LOAD, sss_pkg::MAT_B, 3'd7, 3'd0, 32'h00008000, 1'b0);
    send_request(sss_pkg::MODE_LOAD, sss_pkg::MAT_C, 3'd0, 3'd7, 32'h00007fff, 1'b0);
    send_request(sss_pkg::MODE_LOAD, sss_pkg::MAT_D, 3'd7, 3'd7, 32'hffff8000, 1'b1);
    send_request(sss_pkg::MODE_STATE, sss_pkg::MAT_D, 3'd7, 3'd7, 32'h80000000, 1'b1);
    send_request(sss_pkg::MODE_STATE, sss_pkg::MAT_A, 3'd0, 3'd0, 32'h7fffffff, 1'b0);
    send_request(2'd3, sss_pkg::MAT_C, 3'd3, 3'd3, 32'hffffffff, 1'b1);
    // Saturating row sums through full-scale C and state.
    for (int j = 0; j < 8; j++) begin
      send_request(sss_pkg::MODE_LOAD, sss_pkg::MAT_C, 3'd1, 3'(j), 32'h00007fff, 1'b0);
      send_request(sss_pkg::MODE_STATE, sss_pkg::MAT_A, 3'(j), 3'd0, 32'h7fffffff, 1'b0);
    end
    send_request(sss_pkg::MODE_SAMPLE, sss_pkg::MAT_A, 3'd0, 3'd5, 32'h7fff, 1'b1);
    drain_rows();

    // No states: outputs are D u.
    write_config(4'd0, 4'd3, 4'd1);
    send_sample(3);
    drain_rows();

    // Random phases with varied sizes.
    while (n_sent < 340) begin
      case ($urandom_range(0, 5))
        0: begin n = 8; m = 8; p = 8; end
        1: begin n = 0; m = $urandom_range(1, 8); p = $urandom_range(1, 8); end
        2: begin n = $urandom_range(1, 8); m = $urandom_range(1, 8); p = 0; end
        default: begin
          n = $urandom_range(0, 4); m = $urandom_range(1, 4); p = $urandom_range(1, 4);
        end
      endcase
      if (n_sent > 260) calm = 1;
      write_config((n == 8 && $urandom_range(0, 1)) ? 4'd15 : 4'(n), 4'(m), 4'(p));
      load_system(n, m, p);
      // First sample sends every input so no unwritten element is read.
      send_sample(m);
      if (n_sent > 120 && !hold_done && p != 0) begin
        hold_output = 1;
        hold_done = 1;
      end
      for (int s = 0; s < 3; s++) begin
        if ($urandom_range(0, 3) == 0) begin
          // Partial sample: unused-range elements are kept from earlier samples.
          send_request(sss_pkg::MODE_SAMPLE, sss_pkg::MAT_B, 3'd0,
                       3'($urandom_range(0, m - 1)), rand_coef(), 1'b1);
        end else begin
          send_sample(m);
        end
      end
      // Sender pauses until all rows have come.
      drain_rows();
    end

    drain_rows();
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
